>>> src/dtl_pkg.sv
package dtl_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 24;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int TYPE_W = 5;
  localparam int OFF_W  = 32;
  localparam int LINE_W = 24;
  localparam int LEN_W  = 16;

  typedef enum logic [TYPE_W-1:0] {
    T_COMMA      = 5'd0,
    T_PERIOD     = 5'd1,
    T_QMARK      = 5'd2,
    T_LPAREN     = 5'd3,
    T_RPAREN     = 5'd4,
    T_MUL        = 5'd5,
    T_ADD        = 5'd6,
    T_COLON      = 5'd7,
    T_COLON_DASH = 5'd8,
    T_ID         = 5'd9,
    T_SCHEMES    = 5'd10,
    T_FACTS      = 5'd11,
    T_RULES      = 5'd12,
    T_QUERIES    = 5'd13,
    T_STRING     = 5'd14,
    T_COMMENT    = 5'd15,
    T_UNDEF      = 5'd16,
    T_END        = 5'd17
  } tok_type_t;

  typedef struct packed {
    tok_type_t         ttype;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } token_t;

  // up to two tokens per request
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } tok_pair_t;

  localparam int PAIR_W = $bits(tok_pair_t);

  localparam logic [7:0] CH_POUND = 8'h23;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // keyword characters, position 0..6; zero past the end
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [55:0] s;
    s = 56'h0;
    case (k)
      2'd0: s = "Schemes";
      2'd1: s = {"Facts", 16'h0};
      2'd2: s = {"Rules", 16'h0};
      default: s = "Queries";
    endcase
    kw_char = s[8*(6-p) +: 8];
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    kw_len = (k == 2'd0 || k == 2'd3) ? 3'd7 : 3'd5;
  endfunction

endpackage

>>> src/dtl_fifo.sv
module dtl_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> src/dtl_front.sv
module dtl_front #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int LENGTH_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [7:0]              ch,
  output logic                    q_valid,
  input  logic                    q_ready,
  output dtl_pkg::tok_pair_t      q_data,
  output logic                    q_none
);
  import dtl_pkg::*;

  typedef enum logic [3:0] {
    M_START, M_COLON, M_IDENT, M_STR, M_STR_Q, M_POUND, M_LCOM, M_BCOM, M_BAR
  } mode_t;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  mode_t                  mode_r, mode_nxt;
  logic [3:0]             kw_r, kw_nxt;
  logic [OFFSET_BITS-1:0] soff_r, soff_nxt, coff_r;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt, cline_r;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  token_t pend, single;
  logic   emit_p, emit_s;
  tok_type_t ptype;
  logic   acc;

  logic is_alpha, is_digit, is_space;
  logic [7:0] lc;
  logic [3:0] kw_upd;
  logic [3:0] kw_start;
  logic [LENGTH_BITS-1:0] len_inc;

  assign lc       = ch | 8'h20;
  assign is_alpha = (lc >= "a") && (lc <= "z");
  assign is_digit = (ch >= "0") && (ch <= "9");
  assign is_space = (ch == " ") || (ch >= 8'h09 && ch <= 8'h0D);
  assign len_inc  = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;

  // candidates surviving the current character at position len_r
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      kw_upd[k]   = kw_r[k] && (len_r < LENGTH_BITS'(kw_len(2'(k))))
                    && (kw_char(2'(k), len_r[2:0]) == ch);
      kw_start[k] = (kw_char(2'(k), 3'd0) == ch);
    end
  end

  always_comb begin
    ptype = T_ID;
    for (int k = 3; k >= 0; k--)
      if (kw_r[k] && len_r == LENGTH_BITS'(kw_len(2'(k)))) ptype = tok_type_t'(T_SCHEMES + k);
  end

  always_comb begin
    mode_nxt  = mode_r;
    kw_nxt    = kw_r;
    soff_nxt  = soff_r;
    sline_nxt = sline_r;
    len_nxt   = len_r;
    emit_p    = 1'b0;
    emit_s    = 1'b0;
    pend.ttype  = T_ID;
    pend.line   = LINE_W'(sline_r);
    pend.offset = OFF_W'(soff_r);
    pend.length = LEN_W'(len_r);
    single.ttype  = T_UNDEF;
    single.line   = LINE_W'(cline_r);
    single.offset = OFF_W'(coff_r);
    single.length = LEN_W'(1);
    begin : run
      logic do_start;
      do_start = 1'b0;
      if (kind) begin
        emit_p = 1'b1;
        unique case (mode_r)
          M_COLON:         pend.ttype = T_COLON;
          M_IDENT:         pend.ttype = ptype;
          M_STR_Q:         pend.ttype = T_STRING;
          M_POUND, M_LCOM: pend.ttype = T_COMMENT;
          M_STR, M_BCOM, M_BAR: pend.ttype = T_UNDEF;
          default:         emit_p = 1'b0;
        endcase
        mode_nxt = M_START;
        emit_s = 1'b1;
        single.ttype = T_END;
        single.length = '0;
      end else begin
        unique case (mode_r)
          M_COLON: begin
            emit_p = 1'b1;
            mode_nxt = M_START;
            if (ch == CH_DASH) begin
              pend.ttype = T_COLON_DASH;
              pend.length = LEN_W'(len_inc);
            end else begin
              pend.ttype = T_COLON;
              do_start = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha || is_digit) begin
              kw_nxt = kw_upd;
              len_nxt = len_inc;
            end else begin
              emit_p = 1'b1;
              pend.ttype = ptype;
              mode_nxt = M_START;
              do_start = 1'b1;
            end
          end
          M_STR: begin
            len_nxt = len_inc;
            if (ch == CH_QUOTE) mode_nxt = M_STR_Q;
          end
          M_STR_Q: begin
            if (ch == CH_QUOTE) begin
              len_nxt = len_inc;
              mode_nxt = M_STR;
            end else begin
              emit_p = 1'b1;
              pend.ttype = T_STRING;
              mode_nxt = M_START;
              do_start = 1'b1;
            end
          end
          M_POUND, M_LCOM: begin
            if (ch == CH_NL) begin
              emit_p = 1'b1;
              pend.ttype = T_COMMENT;
              mode_nxt = M_START;
              do_start = 1'b1;
            end else begin
              len_nxt = len_inc;
              if (mode_r == M_POUND) mode_nxt = (ch == CH_BAR) ? M_BCOM : M_LCOM;
            end
          end
          M_BCOM: begin
            len_nxt = len_inc;
            if (ch == CH_BAR) mode_nxt = M_BAR;
          end
          M_BAR: begin
            len_nxt = len_inc;
            if (ch == CH_POUND) begin
              emit_p = 1'b1;
              pend.ttype = T_COMMENT;
              pend.length = LEN_W'(len_inc);
              mode_nxt = M_START;
            end else if (ch != CH_BAR) begin
              mode_nxt = M_BCOM;
            end
          end
          default: do_start = 1'b1;
        endcase
        if (do_start) begin
          mode_nxt = M_START;
          emit_s = 1'b1;
          case (ch)
            ",": single.ttype = T_COMMA;
            ".": single.ttype = T_PERIOD;
            "?": single.ttype = T_QMARK;
            "(": single.ttype = T_LPAREN;
            ")": single.ttype = T_RPAREN;
            "*": single.ttype = T_MUL;
            "+": single.ttype = T_ADD;
            default: begin
              if (ch == CH_COLON || ch == CH_QUOTE || ch == CH_POUND || is_alpha) begin
                emit_s = 1'b0;
                soff_nxt = coff_r;
                sline_nxt = cline_r;
                len_nxt = LENGTH_BITS'(1);
                if (ch == CH_COLON) mode_nxt = M_COLON;
                else if (ch == CH_QUOTE) mode_nxt = M_STR;
                else if (ch == CH_POUND) mode_nxt = M_POUND;
                else begin
                  mode_nxt = M_IDENT;
                  kw_nxt = kw_start;
                end
              end else if (is_space) begin
                emit_s = 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;
  assign q_valid  = acc && (emit_p || emit_s);
  assign q_none   = !(emit_p || emit_s);
  assign q_data.two = emit_p && emit_s;
  assign q_data.t0  = emit_p ? pend : single;
  assign q_data.t1  = single;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_START;
      kw_r    <= 4'hF;
      soff_r  <= '0;
      sline_r <= LINE_BITS'(1);
      cline_r <= LINE_BITS'(1);
      coff_r  <= '0;
      len_r   <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      kw_r    <= kw_nxt;
      soff_r  <= soff_nxt;
      sline_r <= sline_nxt;
      len_r   <= len_nxt;
      if (!kind) begin
        coff_r <= coff_r + 1'b1;
        if (ch == CH_NL && cline_r != LINE_MAX) cline_r <= cline_r + 1'b1;
      end
    end
  end
endmodule

>>> src/dtl_back.sv
module dtl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  dtl_pkg::tok_pair_t q_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [79:0]        out_tdata,
  output logic               out_tlast
);
  import dtl_pkg::*;

  logic   sel_r;
  token_t tk;
  logic   last, take;

  assign tk   = sel_r ? q_data.t1 : q_data.t0;
  assign last = !q_data.two || sel_r;
  assign out_tvalid = q_valid;
  assign out_tdata  = {3'b000, tk.length, tk.offset, tk.line, tk.ttype};
  assign out_tlast  = last;
  assign take       = q_valid && out_tready;
  assign q_ready    = out_tready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (take) sel_r <= !last;
  end
endmodule

>>> src/datalog_token_lexer.sv
// A token is registered in the two-entry token queue before it is offered.
// Throughput: one character per cycle while the token queue has room; a
// character yielding two tokens sends them in turn on the single token output port.
// Reset: synchronous active-low rst_n returns the lexer to its start mode,
// line 1, offset 0, and empties the token queue.
module datalog_token_lexer #(
  parameter int OFFSET_BITS = dtl_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = dtl_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = dtl_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // ch
  input  logic        in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata, // token_type, start_line, start_offset, token_length
  output logic        out_tlast  // last_of_item
);
  import dtl_pkg::*;

  logic      f_valid, f_ready, f_none;
  tok_pair_t f_data, b_data;
  logic      b_valid, b_ready;

  dtl_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
              .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tuser), .ch(in_tdata),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data), .q_none(f_none)
  );

  dtl_fifo #(.W(PAIR_W)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  dtl_back u_back (
    .clk, .rst_n,
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

`ifndef SYNTHESIS
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == T_END |-> out_tlast) else $error("end token not last");
  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == T_END |-> out_tdata[79:64] == 16'h0)
    else $error("end token length");
  a_none_noq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && f_none |-> !f_valid) else $error("empty request queued");
`endif
endmodule
